[hw/rtl/ssbr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ssbr_pkg
// Shared constants, types and helpers for the screen-space bounding rectangle
// ----------------------------------------------------------------------------
package ssbr_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int OUT_FRAC      = 16;
    localparam int NUM_CFG_REGS  = 8;
    localparam int CFG_IDX_W     = 4;
    localparam int CFG_DATA_W    = 64;
    localparam int COORD_W       = 32;
    localparam int RECT_W        = 17;

    typedef logic [NUM_CFG_REGS-1:0][CFG_DATA_W-1:0] mat_regs_t;

    // clip-space x, y and w of one corner
    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cw;
    } clip_t;

    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > $signed(64'h0000_0000_7FFF_FFFF))
            r = $signed(32'h7FFF_FFFF);
        else if (v < $signed(64'hFFFF_FFFF_8000_0000))
            r = $signed(32'h8000_0000);
        else
            r = v[COORD_W-1:0];
        return r;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/ssbr_mac.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ssbr_mac
// Shared multiply-accumulate unit: clip rows x, y and w, one product a cycle
// ----------------------------------------------------------------------------
module ssbr_mac #(
    parameter int FRAC_BITS = ssbr_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire ssbr_pkg::mat_regs_t         mat,
    input  wire logic signed [31:0]          vx,
    input  wire logic signed [31:0]          vy,
    input  wire logic signed [31:0]          vz,
    output ssbr_pkg::clip_t                  res,
    output logic                             done
);
    import ssbr_pkg::*;

    localparam int ACC_W    = 66 - FRAC_BITS;
    localparam int NUM_MACS = 12;
    localparam logic signed [COORD_W-1:0] ONE = COORD_W'(1) << FRAC_BITS;

    logic [3:0]               cnt_reg, cnt_next;
    logic                     busy_reg, busy_next;
    logic signed [63:0]       prod_reg, prod_next;
    logic                     pvalid_reg;
    logic                     plast_reg;
    logic [1:0]               prow_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic                     done_reg;
    clip_t                    res_reg, res_next;

    logic [1:0]               row_sel;
    logic [1:0]               col_sel;
    logic [1:0]               mrow;
    logic [2:0]               mat_idx;
    logic signed [31:0]       op_a;
    logic signed [31:0]       op_b;
    logic signed [ACC_W-1:0]  sum;
    logic signed [COORD_W-1:0] sat_sum;

    assign row_sel = cnt_reg[3:2];
    assign col_sel = cnt_reg[1:0];
    // third row pass uses matrix row 3 (clip w)
    assign mrow    = (row_sel == 2'd2) ? 2'd3 : row_sel;
    assign mat_idx = {mrow, col_sel[1]};
    assign op_a    = col_sel[0] ? mat[mat_idx][31:0] : mat[mat_idx][63:32];

    always_comb
    begin
        unique case (col_sel)
            2'd0:    op_b = vx;
            2'd1:    op_b = vy;
            2'd2:    op_b = vz;
            default: op_b = ONE;
        endcase
    end

    assign prod_next = 64'(op_a) * 64'(op_b);
    assign sum       = acc_reg + ACC_W'(prod_reg >>> FRAC_BITS);
    assign sat_sum   = sat32(64'(sum));

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'(NUM_MACS - 1))
                busy_next = 1'b0;
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        res_next = res_reg;
        if (pvalid_reg)
        begin
            if (plast_reg)
            begin
                acc_next = '0;
                case (prow_reg)
                    2'd0:    res_next.cx = sat_sum;
                    2'd1:    res_next.cy = sat_sum;
                    default: res_next.cw = sat_sum;
                endcase
            end
            else
            begin
                acc_next = sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            busy_reg   <= 1'b0;
            pvalid_reg <= 1'b0;
            plast_reg  <= 1'b0;
            prow_reg   <= '0;
            acc_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            busy_reg   <= busy_next;
            pvalid_reg <= busy_reg;
            plast_reg  <= (col_sel == 2'd3);
            prow_reg   <= row_sel;
            acc_reg    <= acc_next;
            done_reg   <= pvalid_reg && plast_reg && (prow_reg == 2'd2);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        res_reg  <= res_next;
    end

    assign res  = res_reg;
    assign done = done_reg;

endmodule
`default_nettype wire

[hw/rtl/ssbr_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ssbr_div
// Bit-serial divider: perspective divide by clip w and half-plus-half mapping
// ----------------------------------------------------------------------------
module ssbr_div #(
    parameter int FRAC_BITS = ssbr_pkg::FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [31:0] num,
    input  wire logic signed [31:0] den,
    output logic signed [31:0]      result,
    output logic                    done
);
    import ssbr_pkg::*;

    localparam int DW    = COORD_W + FRAC_BITS;
    localparam int CNT_W = $clog2(DW + 1);
    localparam logic signed [COORD_W-1:0] HALF = COORD_W'(1) << (FRAC_BITS - 1);

    logic [DW-1:0]             quo_reg;
    logic [COORD_W-1:0]        rem_reg;
    logic [COORD_W-1:0]        den_reg;
    logic                      neg_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      busy_reg;
    logic                      fin_reg;
    logic                      done_reg;
    logic signed [COORD_W-1:0] result_reg;

    logic [COORD_W-1:0]        num_mag;
    logic [COORD_W-1:0]        den_mag;
    logic [COORD_W:0]          trial;
    logic                      ge;
    logic [COORD_W:0]          diff;
    logic signed [COORD_W-1:0] q_sat;
    logic signed [COORD_W-1:0] mapped;

    assign num_mag = num[31] ? (~num + 32'd1) : num;
    assign den_mag = den[31] ? (~den + 32'd1) : den;
    assign trial   = {rem_reg, quo_reg[DW-1]};
    assign ge      = trial >= {1'b0, den_reg};
    assign diff    = trial - {1'b0, den_reg};

    // truncated quotient with its sign applied, saturated to 32 bits signed
    always_comb
    begin
        if (!neg_reg)
        begin
            if (|quo_reg[DW-1:31])
                q_sat = $signed(32'h7FFF_FFFF);
            else
                q_sat = $signed(quo_reg[31:0]);
        end
        else
        begin
            if ((|quo_reg[DW-1:32]) || (quo_reg[31] && (|quo_reg[30:0])))
                q_sat = $signed(32'h8000_0000);
            else
                q_sat = $signed(~quo_reg[31:0] + 32'd1);
        end
    end

    assign mapped = (q_sat >>> 1) + HALF;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(DW);
            busy_reg <= 1'b1;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - CNT_W'(1);
            fin_reg  <= (cnt_reg == CNT_W'(1));
            done_reg <= 1'b0;
            if (cnt_reg == CNT_W'(1))
                busy_reg <= 1'b0;
        end
        else
        begin
            fin_reg  <= 1'b0;
            done_reg <= fin_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= {num_mag, {FRAC_BITS{1'b0}}};
            rem_reg <= '0;
            den_reg <= den_mag;
            neg_reg <= num[31] ^ den[31];
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DW-2:0], ge};
            rem_reg <= ge ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
        end
        if (fin_reg)
            result_reg <= mapped;
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule
`default_nettype wire

[hw/rtl/screen_space_bounding_rect_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// screen_space_bounding_rect_top
// Screen rectangle covered by a projected light volume
// ----------------------------------------------------------------------------
// Corners of a light volume enter on the s_ stream, one per transaction, the
// final one marked by s_tlast. Each corner is run through the 4x4 matrix held
// in eight 64-bit registers (cfg_we/cfg_index/cfg_data, identity at reset).
// On the final corner one rectangle transaction leaves on the m_ stream;
// other corners give nothing on m_ and only update the running extremes.
// For each corner the twelve products go one per cycle through a single
// multiplier; unless clip w is zero, x and y are then divided in turn by one
// divider producing one quotient bit per cycle. When clip w is zero the
// divisions are skipped.
// s_tready is high only between corners. The result sits in an output
// register, so a stalled m_ side holds only a final corner that finds the
// previous rectangle still waiting there. Reset clears the extremes, the
// behind-viewer flag and the output valid and loads the identity matrix.
// ----------------------------------------------------------------------------
module screen_space_bounding_rect_top #(
    parameter int FRAC_BITS = ssbr_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // s_tdata: corner_x[31:0], corner_y[63:32], corner_z[95:64]
    input  wire logic [95:0]                       s_tdata,
    input  wire logic                              s_tlast,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // m_tdata: rect_left[16:0], rect_top[33:17], rect_width[50:34],
    //          rect_height[67:51], zero pad[71:68]
    output logic [71:0]                            m_tdata,
    // m_tuser: viewer_inside[0]
    output logic                                   m_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic                              cfg_we,
    input  wire logic [ssbr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ssbr_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import ssbr_pkg::*;

    localparam logic signed [COORD_W-1:0] ONE = COORD_W'(1) << FRAC_BITS;
    localparam int SH_R = (FRAC_BITS >= OUT_FRAC) ? FRAC_BITS - OUT_FRAC : 0;
    localparam int SH_L = (FRAC_BITS <  OUT_FRAC) ? OUT_FRAC - FRAC_BITS : 0;
    localparam logic signed [COORD_W-1:0] POS_MAX = $signed(32'h7FFF_FFFF);
    localparam logic signed [COORD_W-1:0] NEG_MAX = $signed(32'h8000_0000);
    localparam logic [CFG_DATA_W-1:0] DIAG_HI = CFG_DATA_W'(1) << (32 + FRAC_BITS);
    localparam logic [CFG_DATA_W-1:0] DIAG_LO = CFG_DATA_W'(1) << FRAC_BITS;
    // identity: registers 0 and 5 carry the upper diagonal entry, 2 and 7 the lower
    localparam mat_regs_t MAT_RESET = {DIAG_LO, {CFG_DATA_W{1'b0}}, DIAG_HI,
                                       {(2*CFG_DATA_W){1'b0}}, DIAG_LO,
                                       {CFG_DATA_W{1'b0}}, DIAG_HI};

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_MAC    = 6'b000010,
        ST_DIVX   = 6'b000100,
        ST_DIVY   = 6'b001000,
        ST_UPDATE = 6'b010000,
        ST_EMIT   = 6'b100000
    } state_t;

    state_t                    state_reg, state_next;
    mat_regs_t                 mat_reg;
    logic signed [COORD_W-1:0] vx_reg, vy_reg, vz_reg;
    logic                      last_reg;
    logic signed [COORD_W-1:0] cx_reg, cy_reg, cw_reg;
    logic signed [COORD_W-1:0] least_x_reg, least_y_reg;
    logic signed [COORD_W-1:0] greatest_x_reg, greatest_y_reg;
    logic                      behind_reg;
    logic                      m_tvalid_reg;
    logic [4*RECT_W-1:0]       rect_reg;
    logic                      inside_reg;

    logic                      s_accept;
    logic                      m_accept;
    logic                      out_load;
    clip_t                     mac_res;
    logic                      mac_done;
    logic                      div_start;
    logic signed [COORD_W-1:0] div_num, div_den;
    logic signed [COORD_W-1:0] div_result;
    logic                      div_done;
    logic [RECT_W-1:0]         r_left, r_top, r_width, r_height;

    function automatic logic signed [COORD_W-1:0] clamp01(input logic signed [COORD_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        if (v < 0)
            r = '0;
        else if (v > ONE)
            r = ONE;
        else
            r = v;
        return r;
    endfunction

    function automatic logic [RECT_W-1:0] to_out(input logic [COORD_W-1:0] v);
        logic [COORD_W-1:0] t;
        t = (v >> SH_R) << SH_L;
        return t[RECT_W-1:0];
    endfunction

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_accept = m_tvalid_reg && m_tready;
    assign out_load = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);

    ssbr_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .start (s_accept),
        .mat   (mat_reg),
        .vx    ($signed(s_accept ? s_tdata[31:0]  : vx_reg)),
        .vy    ($signed(s_accept ? s_tdata[63:32] : vy_reg)),
        .vz    ($signed(s_accept ? s_tdata[95:64] : vz_reg)),
        .res   (mac_res),
        .done  (mac_done)
    );

    // first division straight from the mac result, second from the held y
    assign div_start = ((state_reg == ST_MAC) && mac_done && (mac_res.cw != 0)) ||
                       ((state_reg == ST_DIVX) && div_done);
    assign div_num   = (state_reg == ST_MAC) ? mac_res.cx : cy_reg;
    assign div_den   = (state_reg == ST_MAC) ? mac_res.cw : cw_reg;

    ssbr_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (div_num),
        .den    (div_den),
        .result (div_result),
        .done   (div_done)
    );

    always_comb
    begin
        logic signed [COORD_W-1:0] lx, ly, gx, gy;
        lx = clamp01(least_x_reg);
        ly = clamp01(least_y_reg);
        gx = clamp01(greatest_x_reg);
        gy = clamp01(greatest_y_reg);
        if (behind_reg)
        begin
            r_left   = '0;
            r_top    = '0;
            r_width  = to_out(ONE);
            r_height = to_out(ONE);
        end
        else
        begin
            r_left   = to_out(lx);
            r_top    = to_out(ly);
            r_width  = to_out(gx - lx);
            r_height = to_out(gy - ly);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (s_accept)
                    state_next = ST_MAC;
            ST_MAC:
                if (mac_done)
                    state_next = (mac_res.cw != 0) ? ST_DIVX : ST_UPDATE;
            ST_DIVX:
                if (div_done)
                    state_next = ST_DIVY;
            ST_DIVY:
                if (div_done)
                    state_next = ST_UPDATE;
            ST_UPDATE:
                state_next = last_reg ? ST_EMIT : ST_IDLE;
            ST_EMIT:
                if (out_load)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mat_reg        <= MAT_RESET;
            least_x_reg    <= POS_MAX;
            least_y_reg    <= POS_MAX;
            greatest_x_reg <= NEG_MAX;
            greatest_y_reg <= NEG_MAX;
            behind_reg     <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_CFG_REGS)))
                mat_reg[cfg_index[2:0]] <= cfg_data;

            if (state_reg == ST_UPDATE)
            begin
                if (cw_reg < 0)
                    behind_reg <= 1'b1;
                if (cx_reg < least_x_reg)
                    least_x_reg <= cx_reg;
                if (cy_reg < least_y_reg)
                    least_y_reg <= cy_reg;
                if (cx_reg > greatest_x_reg)
                    greatest_x_reg <= cx_reg;
                if (cy_reg > greatest_y_reg)
                    greatest_y_reg <= cy_reg;
            end

            if (out_load)
            begin
                m_tvalid_reg   <= 1'b1;
                least_x_reg    <= POS_MAX;
                least_y_reg    <= POS_MAX;
                greatest_x_reg <= NEG_MAX;
                greatest_y_reg <= NEG_MAX;
                behind_reg     <= 1'b0;
            end
            else if (m_accept)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            vx_reg   <= $signed(s_tdata[31:0]);
            vy_reg   <= $signed(s_tdata[63:32]);
            vz_reg   <= $signed(s_tdata[95:64]);
            last_reg <= s_tlast;
        end
        if ((state_reg == ST_MAC) && mac_done)
        begin
            cx_reg <= mac_res.cx;
            cy_reg <= mac_res.cy;
            cw_reg <= mac_res.cw;
        end
        if ((state_reg == ST_DIVX) && div_done)
            cx_reg <= div_result;
        if ((state_reg == ST_DIVY) && div_done)
            cy_reg <= div_result;
        if (out_load)
        begin
            rect_reg   <= {r_height, r_width, r_top, r_left};
            inside_reg <= behind_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, rect_reg};
    assign m_tuser  = inside_reg;

endmodule
`default_nettype wire

[hw/rtl/ssbr_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ssbr_checker
// Port-level checks for the screen-space bounding rectangle block
// ----------------------------------------------------------------------------
module ssbr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [71:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready
);

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a corner is never taken back to back: s_tready drops after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again right after a corner");

    // behind-viewer result is the full screen
    a_full_screen: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata[33:0] == 34'd0) &&
                                (m_tdata[50:34] == 17'h10000) &&
                                (m_tdata[67:51] == 17'h10000))
        else $error("viewer inside without full screen");

    // rectangle stays on screen
    a_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ({1'b0, m_tdata[16:0]} + {1'b0, m_tdata[50:34]} <= 18'h10000) &&
                     ({1'b0, m_tdata[33:17]} + {1'b0, m_tdata[67:51]} <= 18'h10000))
        else $error("rectangle leaves the screen");

endmodule

bind screen_space_bounding_rect_top ssbr_checker u_ssbr_checker (.*);
`default_nettype wire
